FILE: hdl/psmc_pkg.sv
// shared types, constants and helpers for the ps/2 mouse packet cursor
`default_nettype none

package psmc_pkg;

  // header byte marks
  localparam logic [7:0] HDR_SYNC_BIT  = 8'h08;
  localparam logic [7:0] HDR_ZERO_BITS = 8'hC0;
  localparam logic [7:0] HDR_BTN_MASK  = 8'h07;
  localparam int         HDR_XSIGN     = 4;
  localparam int         HDR_YSIGN     = 5;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LIM_W   = 12;
  localparam int GAIN_W  = 4;
  localparam int BTN_W   = 3;
  localparam int MOVE_W  = 13;
  localparam int CIDX_W  = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_X_LIMIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_Y_LIMIT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GAIN    = 2'd2;

  // configuration reset values
  localparam logic [LIM_W-1:0]  X_LIMIT_RST = 12'd1023;
  localparam logic [LIM_W-1:0]  Y_LIMIT_RST = 12'd767;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 4'd2;

  // cursor reset values before reduction to the position range
  localparam int CURSOR_X_RST = 512;
  localparam int CURSOR_Y_RST = 384;

  // configuration as seen by the back end
  typedef struct packed {
    logic [LIM_W-1:0]  x_limit;
    logic [LIM_W-1:0]  y_limit;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // one assembled mouse packet
  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] xbyte;
    logic [BYTE_W-1:0] ybyte;
  } pkt_t;

  // a byte that can open a packet
  function automatic logic first_like(input logic [BYTE_W-1:0] b);
    first_like = ((b & HDR_SYNC_BIT) != '0) && ((b & HDR_ZERO_BITS) == '0);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ps2_mouse_packet_cursor.sv
// top level: ps/2 mouse packet decoder with clamped cursor
//
// input words (data_byte, from_aux) are taken when in_valid is high and
// in_stall is low. keyboard bytes (from_aux low) are dropped. mouse bytes
// are assembled into 3-byte packets; each completed packet yields one
// output word (pos_x, pos_y, buttons, move_x, move_y), taken when out_valid
// is high and out_stall is low.
// throughput: one input byte per cycle unless stalled. the accepted third
// byte of a packet passes the queue write, scale stage and cursor add/clamp
// stage before out_valid. a two-entry packet queue sits between the byte
// assembler and the cursor pipeline, so bytes keep flowing while a result
// waits; in_stall rises only when that queue is full. configuration (x_limit,
// y_limit, gain) is written via cfg_valid / cfg_index / cfg_data, always
// ready; the user must write it only while the block is idle, not enforced
// by the block. reset (rst, synchronous) sets limits 1023/767, gain 2, cursor
// 512/384 (capped at the position range) and waits for a packet header.
`default_nettype none

module ps2_mouse_packet_cursor #(
  parameter int POS_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  from_aux,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [POS_BITS-1:0]        pos_x,
  output logic [POS_BITS-1:0]        pos_y,
  output logic [2:0]                 buttons,
  output logic signed [12:0]         move_x,
  output logic signed [12:0]         move_y,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [11:0]           cfg_data
);

  psmc_pkg::cfg_t cfg;
  psmc_pkg::pkt_t push_pkt;
  psmc_pkg::pkt_t q_head;
  logic           push;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;
  logic           in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_limit <= psmc_pkg::X_LIMIT_RST;
      cfg.y_limit <= psmc_pkg::Y_LIMIT_RST;
      cfg.gain    <= psmc_pkg::GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psmc_pkg::CFG_X_LIMIT: cfg.x_limit <= cfg_data;
        psmc_pkg::CFG_Y_LIMIT: cfg.y_limit <= cfg_data;
        psmc_pkg::CFG_GAIN:    cfg.gain    <= cfg_data[psmc_pkg::GAIN_W-1:0];
        default:               cfg.gain    <= cfg.gain;
      endcase
    end
  end

  psmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .from_aux  (from_aux),
    .push      (push),
    .push_pkt  (push_pkt)
  );

  psmc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (q_pop),
    .full     (q_full),
    .avail    (q_avail),
    .head     (q_head)
  );

  psmc_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .buttons   (buttons),
    .move_x    (move_x),
    .move_y    (move_y)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("packet queue written while full");

  // delivered x position lies within the configured limit
  a_pos_x_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(pos_x) <= 32'(cfg.x_limit)))
    else $error("pos_x beyond x_limit");

  // delivered y position lies within the configured limit
  a_pos_y_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(pos_y) <= 32'(cfg.y_limit)))
    else $error("pos_y beyond y_limit");

  // zero gain gives zero moves
  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfg.gain == '0) |-> (move_x == '0 && move_y == '0))
    else $error("nonzero move with zero gain");

endmodule

`default_nettype wire

FILE: hdl/psmc_front.sv
// front end: filters keyboard bytes and assembles 3-byte mouse packets
`default_nettype none

module psmc_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     from_aux,
  output logic                          push,
  output psmc_pkg::pkt_t                push_pkt
);

  typedef enum logic [1:0] {
    WAIT_HDR,
    WAIT_X,
    WAIT_Y
  } pos_t;

  pos_t       pos;
  pos_t       pos_next;
  logic [7:0] header;
  logic [7:0] xbyte;
  logic       take;
  logic       is_first;

  assign take     = accept && from_aux;
  assign is_first = psmc_pkg::first_like(data_byte);

  // next byte position
  always_comb begin
    pos_next = pos;
    push     = 1'b0;
    if (take) begin
      unique case (pos)
        WAIT_HDR: begin
          if (is_first) pos_next = WAIT_X;
        end
        WAIT_X: begin
          pos_next = is_first ? WAIT_X : WAIT_Y;
        end
        WAIT_Y: begin
          if (is_first) begin
            pos_next = WAIT_X;
          end else begin
            pos_next = WAIT_HDR;
            push     = 1'b1;
          end
        end
        default: begin
          if (is_first) pos_next = WAIT_X;
        end
      endcase
    end
  end

  // completed packet word toward the queue
  assign push_pkt = '{header: header, xbyte: xbyte, ybyte: data_byte};

  // position state and captured bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= WAIT_HDR;
      header <= '0;
      xbyte  <= '0;
    end else begin
      pos <= pos_next;
      if (take && is_first) header <= data_byte;
      if (take && !is_first && pos == WAIT_X) xbyte <= data_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/psmc_fifo.sv
// two-entry packet queue between front and back end
`default_nettype none

module psmc_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire psmc_pkg::pkt_t push_pkt,
  input  wire logic           pop,
  output logic                full,
  output logic                avail,
  output psmc_pkg::pkt_t      head
);

  psmc_pkg::pkt_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           do_pop;

  assign full   = (count == 2'd2);
  assign avail  = (count != 2'd0);
  assign do_pop = pop && avail;
  assign head   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_pkt;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      priority case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/psmc_back.sv
// back end: scales the moves, then updates and clamps the cursor
`default_nettype none

module psmc_back #(
  parameter int POS_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire psmc_pkg::cfg_t       cfg,
  input  wire logic                 q_avail,
  input  wire psmc_pkg::pkt_t       q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [POS_BITS-1:0]       pos_x,
  output logic [POS_BITS-1:0]       pos_y,
  output logic [2:0]                buttons,
  output logic signed [12:0]        move_x,
  output logic signed [12:0]        move_y
);

  localparam int PMAX_I = (1 << POS_BITS) - 1;
  localparam int XR_I   = (psmc_pkg::CURSOR_X_RST > PMAX_I) ? PMAX_I : psmc_pkg::CURSOR_X_RST;
  localparam int YR_I   = (psmc_pkg::CURSOR_Y_RST > PMAX_I) ? PMAX_I : psmc_pkg::CURSOR_Y_RST;
  localparam int SUM_W  = ((POS_BITS + 1 > psmc_pkg::MOVE_W) ? POS_BITS + 1
                                                              : psmc_pkg::MOVE_W) + 1;
  localparam logic [POS_BITS-1:0] PMAX = '1;

  // stage one: scaled moves
  logic                               s1_valid;
  logic signed [psmc_pkg::MOVE_W-1:0] s1_mx;
  logic signed [psmc_pkg::MOVE_W-1:0] s1_my;
  logic [2:0]                         s1_btn;
  logic signed [8:0]                  nine_x;
  logic signed [8:0]                  nine_y;
  logic signed [13:0]                 prod_x;
  logic signed [13:0]                 prod_y;
  logic signed [13:0]                 neg_y;
  logic                               s1_en;
  logic                               s2_en;
  logic                               load;

  // stage two: cursor update
  logic [SUM_W-1:0]        lim_x;
  logic [SUM_W-1:0]        lim_y;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [POS_BITS-1:0]     pos_x_next;
  logic [POS_BITS-1:0]     pos_y_next;

  // pipeline flow
  assign s2_en = !out_valid || !out_stall;
  assign s1_en = !s1_valid || s2_en;
  assign q_pop = q_avail && s1_en;
  assign load  = s1_valid && s2_en;

  // sign-extended 9-bit moves times gain
  assign nine_x = {q_head.header[psmc_pkg::HDR_XSIGN], q_head.xbyte};
  assign nine_y = {q_head.header[psmc_pkg::HDR_YSIGN], q_head.ybyte};
  assign prod_x = nine_x * $signed({1'b0, cfg.gain});
  assign prod_y = nine_y * $signed({1'b0, cfg.gain});
  assign neg_y  = -prod_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop || (s1_valid && !s2_en);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_mx  <= prod_x[psmc_pkg::MOVE_W-1:0];
      s1_my  <= neg_y[psmc_pkg::MOVE_W-1:0];
      s1_btn <= q_head.header[2:0] & psmc_pkg::HDR_BTN_MASK[2:0];
    end
  end

  // effective limits, capped at the position range
  assign lim_x = (SUM_W'(cfg.x_limit) > SUM_W'(PMAX)) ? SUM_W'(PMAX) : SUM_W'(cfg.x_limit);
  assign lim_y = (SUM_W'(cfg.y_limit) > SUM_W'(PMAX)) ? SUM_W'(PMAX) : SUM_W'(cfg.y_limit);

  // add and clamp
  assign sum_x = $signed(SUM_W'(pos_x)) + SUM_W'(s1_mx);
  assign sum_y = $signed(SUM_W'(pos_y)) + SUM_W'(s1_my);

  always_comb begin
    priority if (sum_x[SUM_W-1]) begin
      pos_x_next = '0;
    end else if (unsigned'(sum_x) > lim_x) begin
      pos_x_next = lim_x[POS_BITS-1:0];
    end else begin
      pos_x_next = sum_x[POS_BITS-1:0];
    end
  end

  always_comb begin
    priority if (sum_y[SUM_W-1]) begin
      pos_y_next = '0;
    end else if (unsigned'(sum_y) > lim_y) begin
      pos_y_next = lim_y[POS_BITS-1:0];
    end else begin
      pos_y_next = sum_y[POS_BITS-1:0];
    end
  end

  // cursor doubles as the output position register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= POS_BITS'(XR_I);
      pos_y     <= POS_BITS'(YR_I);
    end else begin
      out_valid <= load || (out_valid && out_stall);
      if (load) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buttons <= s1_btn;
      move_x  <= s1_mx;
      move_y  <= s1_my;
    end
  end

endmodule

`default_nettype wire

FILE: sim/ps2_mouse_packet_cursor_test.sv
// testbench for the ps/2 mouse packet cursor: reports predicted per byte, checked per word
module ps2_mouse_packet_cursor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_W             = 12;
  localparam int POS_TOP           = (1 << POS_W) - 1;
  localparam int LATENCY_PAD       = 8;
  localparam int IDLE_PCT          = 37;
  localparam int QUIET_LIMIT       = 5000;
  localparam int RX_HOLD_CYCLES    = 300;
  localparam int ITEM_TARGET       = 650;
  localparam int SHOWN_MISMATCHES  = 10;

  // index with no register behind it, writes to it are dropped
  localparam logic [psmc_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [POS_W-1:0]                   px;
    logic [POS_W-1:0]                   py;
    logic [psmc_pkg::BTN_W-1:0]         btn;
    logic signed [psmc_pkg::MOVE_W-1:0] mx;
    logic signed [psmc_pkg::MOVE_W-1:0] my;
  } cursor_report_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [psmc_pkg::BYTE_W-1:0]        data_byte = '0;
  logic                               from_aux = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [POS_W-1:0]                   pos_x;
  logic [POS_W-1:0]                   pos_y;
  logic [psmc_pkg::BTN_W-1:0]         buttons;
  logic signed [psmc_pkg::MOVE_W-1:0] move_x;
  logic signed [psmc_pkg::MOVE_W-1:0] move_y;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [psmc_pkg::CIDX_W-1:0]        cfg_index = '0;
  logic [psmc_pkg::LIM_W-1:0]         cfg_data = '0;

  // packet tracker and cursor copy
  logic [1:0]                         pkt_pos;
  logic [psmc_pkg::BYTE_W-1:0]        hdr_q;
  logic [psmc_pkg::BYTE_W-1:0]        xbyte_q;
  int                                 cur_x;
  int                                 cur_y;
  logic [psmc_pkg::LIM_W-1:0]         lim_x;
  logic [psmc_pkg::LIM_W-1:0]         lim_y;
  logic [psmc_pkg::GAIN_W-1:0]        gain_q;

  cursor_report_t                     pending_reports[$];

  bit                                 tx_idle_en = 1'b0;
  bit                                 rx_idle_en = 1'b0;
  int                                 rx_hold_left = 0;
  int                                 quiet_cycles = 0;
  int                                 fail_count = 0;
  int                                 mouse_bytes = 0;
  int                                 kbd_bytes = 0;
  int                                 reports_seen = 0;
  int                                 reg_writes = 0;
  int                                 settings_used = 0;

  ps2_mouse_packet_cursor #(.POS_BITS(POS_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .from_aux  (from_aux),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .buttons   (buttons),
    .move_x    (move_x),
    .move_y    (move_y),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_header(input logic [psmc_pkg::BYTE_W-1:0] b);
    return b[3] && (b[7:6] == 2'b00);
  endfunction

  function automatic int clamp_to(input int v, input logic [psmc_pkg::LIM_W-1:0] lim);
    int top;
    top = (int'(lim) > POS_TOP) ? POS_TOP : int'(lim);
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void reset_tracker();
    pkt_pos = 2'd0;
    hdr_q   = '0;
    xbyte_q = '0;
    cur_x   = (psmc_pkg::CURSOR_X_RST > POS_TOP) ? POS_TOP : psmc_pkg::CURSOR_X_RST;
    cur_y   = (psmc_pkg::CURSOR_Y_RST > POS_TOP) ? POS_TOP : psmc_pkg::CURSOR_Y_RST;
    lim_x   = psmc_pkg::X_LIMIT_RST;
    lim_y   = psmc_pkg::Y_LIMIT_RST;
    gain_q  = psmc_pkg::GAIN_RST;
  endfunction

  // follow one accepted byte, queue a report when a packet completes
  function automatic void track_packet_byte(input logic [psmc_pkg::BYTE_W-1:0] b,
                                            input logic aux);
    int xv;
    int yv;
    int dx;
    int dy;
    cursor_report_t r;
    if (!aux) begin
      kbd_bytes++;
      return;
    end
    mouse_bytes++;
    // waiting for a header, or a header-like byte restarts the packet
    if (pkt_pos != 2'd1 && pkt_pos != 2'd2) begin
      if (is_header(b)) begin
        hdr_q   = b;
        pkt_pos = 2'd1;
      end
      return;
    end
    if (is_header(b)) begin
      hdr_q   = b;
      pkt_pos = 2'd1;
      return;
    end
    if (pkt_pos == 2'd1) begin
      xbyte_q = b;
      pkt_pos = 2'd2;
      return;
    end
    // third byte: decode, scale, move and clamp
    pkt_pos = 2'd0;
    xv = int'(xbyte_q) - (hdr_q[psmc_pkg::HDR_XSIGN] ? 256 : 0);
    yv = int'(b) - (hdr_q[psmc_pkg::HDR_YSIGN] ? 256 : 0);
    dx = xv * int'(gain_q);
    dy = -yv * int'(gain_q);
    cur_x = clamp_to(cur_x + dx, lim_x);
    cur_y = clamp_to(cur_y + dy, lim_y);
    r.px  = POS_W'(cur_x);
    r.py  = POS_W'(cur_y);
    r.btn = hdr_q[psmc_pkg::BTN_W-1:0];
    r.mx  = psmc_pkg::MOVE_W'(dx);
    r.my  = psmc_pkg::MOVE_W'(dy);
    pending_reports.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_reports
    cursor_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        if (fail_count < SHOWN_MISMATCHES)
          $display("unexpected report: x=%0d y=%0d btn=%0d mx=%0d my=%0d",
                   pos_x, pos_y, buttons, move_x, move_y);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (pos_x !== want.px || pos_y !== want.py || buttons !== want.btn ||
            move_x !== want.mx || move_y !== want.my) begin
          if (fail_count < SHOWN_MISMATCHES)
            $display({"report %0d mismatch: exp x=%0d y=%0d btn=%0d mx=%0d my=%0d, ",
                      "got x=%0d y=%0d btn=%0d mx=%0d my=%0d"},
                     reports_seen, want.px, want.py, want.btn, want.mx, want.my,
                     pos_x, pos_y, buttons, move_x, move_y);
          fail_count++;
        end
      end
      reports_seen++;
    end
  end

  // receiver: long hold when asked, otherwise random stalls when enabled
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_idle_en) begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d reports outstanding",
               quiet_cycles, pending_reports.size());
      $display("** ps2_mouse_packet_cursor: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // offer one byte word, random gaps before it when enabled, junk payload while idle
  task automatic send_word(input logic [psmc_pkg::BYTE_W-1:0] b, input logic aux);
    while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      from_aux  <= 1'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    from_aux  <= aux;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_packet_byte(b, aux);
  endtask

  task automatic send_packet(input logic [psmc_pkg::BYTE_W-1:0] h,
                             input logic [psmc_pkg::BYTE_W-1:0] xb,
                             input logic [psmc_pkg::BYTE_W-1:0] yb);
    send_word(h, 1'b1);
    send_word(xb, 1'b1);
    send_word(yb, 1'b1);
  endtask

  function automatic logic [psmc_pkg::BYTE_W-1:0] rand_header();
    logic [psmc_pkg::BYTE_W-1:0] h;
    h      = 8'($urandom);
    h[7:6] = 2'b00;
    h[3]   = 1'b1;
    return h;
  endfunction

  // mostly a plain move byte, sometimes a header-like one that restarts
  function automatic logic [psmc_pkg::BYTE_W-1:0] rand_move_byte();
    logic [psmc_pkg::BYTE_W-1:0] m;
    m = 8'($urandom);
    if ($urandom_range(0, 3) != 0)
      while (is_header(m)) m = 8'($urandom);
    return m;
  endfunction

  // packet with a valid header and random moves, keyboard bytes mixed in now and then
  task automatic send_random_packet();
    logic [psmc_pkg::BYTE_W-1:0] pkt [3];
    pkt[0] = rand_header();
    pkt[1] = rand_move_byte();
    pkt[2] = rand_move_byte();
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0);
      send_word(pkt[i], 1'b1);
    end
  endtask

  // random stream of about n_items words: mostly packets, some keyboard and noise
  task automatic send_traffic(input int n_items);
    int start;
    int pick;
    start = mouse_bytes + kbd_bytes;
    while ((mouse_bytes + kbd_bytes) - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) send_random_packet();
      else if (pick < 88) send_word(8'($urandom), 1'b0);
      else send_word(8'($urandom), 1'b1);
    end
  endtask

  // stop offering and let every report drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [psmc_pkg::CIDX_W-1:0] idx,
                           input logic [psmc_pkg::LIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      psmc_pkg::CFG_X_LIMIT: lim_x = val;
      psmc_pkg::CFG_Y_LIMIT: lim_y = val;
      psmc_pkg::CFG_GAIN:    gain_q = val[psmc_pkg::GAIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // new settings, only with the block drained; gain upper bits are junk
  task automatic set_config(input logic [psmc_pkg::LIM_W-1:0] xl,
                            input logic [psmc_pkg::LIM_W-1:0] yl,
                            input logic [psmc_pkg::GAIN_W-1:0] g);
    settle();
    write_reg(psmc_pkg::CFG_X_LIMIT, xl);
    write_reg(psmc_pkg::CFG_Y_LIMIT, yl);
    write_reg(psmc_pkg::CFG_GAIN, {8'($urandom), g});
    write_reg(CFG_SPARE, 12'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [psmc_pkg::LIM_W-1:0] rand_limit();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 12'($urandom_range(1, 64));
      default: return 12'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset settings: skipped bytes, keyboard bytes, sign and button extremes, resync
  task automatic test_directed_packets();
    send_word(8'h00, 1'b1);          // no sync bit, skipped
    send_word(8'hC8, 1'b1);          // top bits set, skipped
    send_word(8'h08, 1'b0);          // keyboard header-like byte ignored
    send_packet(8'h0F, 8'h7F, 8'h80);
    send_packet(8'h38, 8'h00, 8'h00);
    send_word(8'h39, 1'b1);
    send_word(8'h18, 1'b0);          // keyboard byte inside a packet
    send_word(8'hFF, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h08, 1'b1);
    send_word(8'h2A, 1'b1);          // header-like at position 1 restarts
    send_word(8'h01, 1'b1);
    send_word(8'h1C, 1'b1);          // header-like at position 2 restarts
    send_packet(8'h90, 8'h80, 8'h08); // 0x90 is no header, lands as the x move
    send_packet(8'h08, 8'h00, 8'h00);
    settle();
  endtask

  // full-scale gain and limits, then gain zero with limits 200/100, then zero limits at full gain
  task automatic test_gain_and_limit_extremes();
    set_config('1, '1, 4'd15);
    send_packet(8'h18, 8'h00, 8'h00);
    send_packet(8'h28, 8'hFF, 8'h00);
    send_packet(8'h08, 8'h00, 8'hFF);
    send_traffic(60);
    set_config(12'd200, 12'd100, 4'd0);
    send_traffic(15);
    set_config('0, '0, 4'd15);
    send_traffic(30);
    settle();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    set_config(rand_limit(), rand_limit(), 4'($urandom));
    tx_idle_en = 1'b0;
    @(negedge clk);
    rx_hold_left = RX_HOLD_CYCLES;
    @(posedge clk);
    repeat (24) send_random_packet();
    tx_idle_en = 1'b1;
    settle();
  endtask

  // no gaps on either side
  task automatic test_steady_stream();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_traffic(90);
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // random settings per phase until enough words went in
  task automatic test_random_settings();
    int n;
    int left;
    while (mouse_bytes + kbd_bytes < ITEM_TARGET) begin
      left = ITEM_TARGET - (mouse_bytes + kbd_bytes);
      n    = $urandom_range(60, 100);
      if (n > left) n = left;
      set_config(rand_limit(), rand_limit(), 4'($urandom_range(0, 15)));
      send_traffic(n);
    end
    settle();
  endtask

  initial begin
    reset_tracker();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    test_directed_packets();
    test_gain_and_limit_extremes();
    test_output_backpressure();
    test_steady_stream();
    test_random_settings();

    settle();
    if (pending_reports.size() != 0) begin
      $display("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end
    $display("run: %0d mouse bytes, %0d keyboard bytes, %0d cursor reports, %0d settings",
             mouse_bytes, kbd_bytes, reports_seen, settings_used);
    $display("run: %0d register writes, %0d failures", reg_writes, fail_count);
    if (fail_count == 0) begin
      $display("** ps2_mouse_packet_cursor: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_cursor: FAILED **");
    end
    $finish;
  end

endmodule
